>>> src/assert_macros.svh
// Assertion macros shared by the clipper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/plck_pkg.sv
// Shared constants, types and helper functions of the polyline clipper.
package plck_pkg;

	// Coordinate width and derived widths
	localparam int COORD_W = 16;
	localparam int DW      = COORD_W + 1;          // difference of two coordinates
	localparam int PW      = 2 * DW;               // product of two differences
	localparam int CNT_W   = $clog2(PW);
	localparam int TDATA_W = ((2 * COORD_W + 7) / 8) * 8;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DW-1:0]      diff_t;
	typedef logic [DW-1:0]             mag_t;

	// Request to the shared multiply-divide unit
	typedef struct packed {
		logic vld;
		mag_t a;
		mag_t b;
		mag_t c;
	} div_req_t;

	// Response of the shared multiply-divide unit
	typedef struct packed {
		logic done;
		mag_t quo;
	} div_rsp_t;

	// One pending result point
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   run_end;
		logic   crossing;
	} slot_t;

	// Sign-extend a coordinate by one bit
	function automatic diff_t sx(coord_t v);
		return {v[COORD_W-1], v};
	endfunction

	// Magnitude of a difference
	function automatic mag_t magn(diff_t v);
		diff_t n;
		n = -v;
		return v[DW-1] ? mag_t'(n) : mag_t'(v);
	endfunction

endpackage

>>> src/plck_muldiv.sv
// Iterative unsigned unit: a multiply state, then a restoring divide, one bit per cycle.
`include "assert_macros.svh"

module plck_muldiv import plck_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [1:0] DV_IDLE = 2'd0;
	localparam logic [1:0] DV_MUL  = 2'd1;
	localparam logic [1:0] DV_DIV  = 2'd2;

	logic [1:0]       st_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	mag_t             a_q;
	mag_t             b_q;
	mag_t             c_q;
	mag_t             rem_q;
	logic [PW-1:0]    quo_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      diff;
	logic             ge;

	// Trial subtract of the divisor from the shifted partial remainder
	assign rem_sh = {rem_q, quo_q[PW-1]};
	assign diff   = rem_sh - {1'b0, c_q};
	assign ge     = !diff[DW];

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				DV_IDLE: begin
					if (req.vld) st_q <= DV_MUL;
				end
				DV_MUL: begin
					cnt_q <= CNT_W'(PW - 1);
					st_q  <= DV_DIV;
				end
				DV_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						st_q   <= DV_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= DV_IDLE;
			endcase
		end
	end

	// Operands, product and quotient/remainder shift
	always_ff @(posedge clk) begin
		if (st_q == DV_IDLE && req.vld) begin
			a_q <= req.a;
			b_q <= req.b;
			c_q <= req.c;
		end
		if (st_q == DV_MUL) begin
			quo_q <= PW'(a_q) * PW'(b_q);
			rem_q <= '0;
		end else if (st_q == DV_DIV) begin
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[PW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q[DW-1:0];

	`ASSERT_ALWAYS(a_start_idle, !(req.vld && st_q != DV_IDLE), "request while unit busy")
	`ASSERT_NEXT(a_done_pulse, rsp.done, !rsp.done, "done held longer than one cycle")

endmodule

>>> src/polyline_clip_below_limit_top.sv
// Polyline clipper against the half plane y <= y_limit, top level.
//
// Vertices arrive on the s_ stream, one polyline after another; visible vertices and the
// points where segments cross y_limit leave on the m_ stream, each visible piece closed by
// tlast. One vertex is handled at a time and s_tready is low until all its results (0 to 2)
// are taken. A vertex whose segment crosses the limit first runs the shared multiply-divide
// unit (a multiply, then a restoring divide) and hands the crossing x over to its results.
// The user must write y_limit through cfg_we only while no vertex is in work; the block
// itself does not enforce this.
`include "assert_macros.svh"

module polyline_clip_below_limit_top import plck_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COORD_W-1:0] cfg_wdata,   // y_limit
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,     // point_x, point_y
	input  logic               s_tlast,     // last_point
	input  logic [0:0]         s_tuser,     // first_point
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,     // out_x, out_y
	output logic               m_tlast,     // run_end
	output logic [0:0]         m_tuser      // last_of_input
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] st_q;
	coord_t     lim_q;
	coord_t     prev_x_q;
	coord_t     prev_y_q;
	logic       prev_out_q;
	coord_t     x1_q;
	logic       neg_q;
	logic       zero_c_q;
	slot_t      slot_q [2];
	logic [1:0] n_q;
	logic       idx_q;

	coord_t     in_x;
	coord_t     in_y;
	logic       first;
	logic       last;
	logic       acc;
	logic       now_out;
	logic       need_div;
	diff_t      dif_a;
	diff_t      dif_b;
	diff_t      dif_c;
	slot_t      sl0;
	slot_t      sl1;
	logic [1:0] n_c;
	diff_t      cross_sum;
	coord_t     cross_x;
	slot_t      cur;
	logic       is_last;
	div_req_t   req;
	div_rsp_t   rsp;

	// Unpack the request
	assign in_x  = coord_t'(s_tdata[COORD_W-1:0]);
	assign in_y  = coord_t'(s_tdata[2*COORD_W-1:COORD_W]);
	assign first = s_tuser[0];
	assign last  = s_tlast;

	assign s_tready = (st_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign now_out  = in_y > lim_q;
	assign need_div = !first && (prev_out_q != now_out);

	// Segment differences for the crossing point
	assign dif_a = sx(lim_q) - sx(prev_y_q);
	assign dif_b = sx(in_x) - sx(prev_x_q);
	assign dif_c = sx(in_y) - sx(prev_y_q);

	assign req.vld = acc && need_div;
	assign req.a   = magn(dif_a);
	assign req.b   = magn(dif_b);
	assign req.c   = magn(dif_c);

	plck_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Build the result list of the incoming vertex
	always_comb begin
		sl0 = '{x: prev_x_q, y: prev_y_q, run_end: 1'b0, crossing: 1'b0};
		sl1 = sl0;
		n_c = 2'd0;
		if (!first) begin
			if (!prev_out_q) begin
				n_c = 2'd1;
				if (now_out) begin
					sl1 = '{x: prev_x_q, y: lim_q, run_end: 1'b1, crossing: 1'b1};
					n_c = 2'd2;
				end
			end else if (!now_out) begin
				sl0 = '{x: prev_x_q, y: lim_q, run_end: 1'b0, crossing: 1'b1};
				n_c = 2'd1;
			end
			if (last && !now_out) begin
				if (n_c == 2'd0) sl0 = '{x: in_x, y: in_y, run_end: 1'b1, crossing: 1'b0};
				else             sl1 = '{x: in_x, y: in_y, run_end: 1'b1, crossing: 1'b0};
				n_c = n_c + 2'd1;
			end
		end
	end

	// Crossing x from the quotient, truncated toward zero; a flat segment keeps x1
	assign cross_sum = zero_c_q ? sx(x1_q) :
		neg_q ? (sx(x1_q) - diff_t'(rsp.quo)) : (sx(x1_q) + diff_t'(rsp.quo));
	assign cross_x   = cross_sum[COORD_W-1:0];

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lim_q <= {1'b0, {(COORD_W-1){1'b1}}};
		else if (cfg_we) lim_q <= coord_t'(cfg_wdata);
	end

	// Sequencer and previous vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_out_q <= 1'b0;
			n_q        <= '0;
			idx_q      <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						prev_x_q   <= in_x;
						prev_y_q   <= in_y;
						prev_out_q <= now_out;
						n_q        <= n_c;
						idx_q      <= 1'b0;
						if (need_div)         st_q <= ST_DIV;
						else if (n_c != 2'd0) st_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					if (rsp.done) st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (is_last) st_q <= ST_IDLE;
						else         idx_q <= 1'b1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the pending results; patch in the crossing x when the unit finishes
	always_ff @(posedge clk) begin
		if (acc) begin
			slot_q[0] <= sl0;
			slot_q[1] <= sl1;
			x1_q      <= prev_x_q;
			neg_q     <= dif_a[DW-1] ^ dif_b[DW-1] ^ dif_c[DW-1];
			zero_c_q  <= (dif_c == '0);
		end else if (st_q == ST_DIV && rsp.done) begin
			if (slot_q[0].crossing) slot_q[0].x <= cross_x;
			if (slot_q[1].crossing) slot_q[1].x <= cross_x;
		end
	end

	// Drive the result stream
	assign cur      = slot_q[idx_q];
	assign is_last  = ({1'b0, idx_q} + 2'd1) == n_q;
	assign m_tvalid = (st_q == ST_EMIT);
	assign m_tdata  = TDATA_W'({cur.y, cur.x});
	assign m_tlast  = cur.run_end;
	assign m_tuser  = is_last;

	`ASSERT_ALWAYS(a_one_item, !(s_tready && m_tvalid), "input taken while results pending")
	`ASSERT_ALWAYS(a_done_in_div, !(rsp.done && st_q != ST_DIV), "quotient with no crossing")

endmodule
